### rtl/core/ils_pkg.sv
package ils_pkg;

    localparam int CMD_W     = 3;
    localparam int POS_W     = 10;
    localparam int VAL_W     = 32;
    localparam int ENTRIES_W = 11;

    localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET        = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET        = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE_VAL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } ils_in_t;

    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] read_value;
        logic [ENTRIES_W-1:0]    entries_after;
    } ils_out_t;

endpackage

### rtl/core/indexed_list_store.sv
// Indexed list store: ordered list of signed 32-bit entries, up to CAPACITY.
//
// Input channel in_valid/in_ready/in_data carries one command word
// (append, insert, set, get, remove value, remove at, clear). Output channel
// out_valid/out_ready/out_data returns exactly one result word per command:
// ok flag, value read by get (0 otherwise), and entry count after the command.
//
// Entries live in one single-port-read, single-port-write RAM; one command is
// worked at a time. Append, set, clear, insert at or past the end, remove at
// the last entry and refused commands go straight to the result; get reads
// one RAM entry first. Other inserts, other removes at and remove value walk
// the RAM read port one entry per cycle over the entries they move or scan.
// The next command is accepted as soon as the previous result is handed to
// the output register, so a waiting result does not block the next command.
//
// Reset clears the entry count and all control; RAM contents are not cleared
// and need no sweep. When out_ready stays low, the output register holds its
// word, the next finished result waits in the sequencer, and in_ready drops.
module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ils_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output ils_out_t out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [VAL_W-1:0] ram_wdata, ram_rdata;
    ils_out_t         res_word;
    logic             res_valid, res_ready;
    logic             out_valid_reg, out_valid_next;
    ils_out_t         out_word_reg;

    ils_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ils_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (in_data),
        .cmd_valid (in_valid),
        .cmd_ready (in_ready),
        .res_word  (res_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_word_reg <= res_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

### rtl/core/ils_ram.sv
module ils_ram
    import ils_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [VAL_W-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/ils_seq.sv
module ils_seq
    import ils_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int AW       = 10,
    parameter int CW       = 11
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ils_in_t          cmd_word,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    output ils_out_t         res_word,
    output logic             res_valid,
    input  logic             res_ready,
    output logic             ram_we,
    output logic [AW-1:0]    ram_waddr,
    output logic [VAL_W-1:0] ram_wdata,
    output logic             ram_re,
    output logic [AW-1:0]    ram_raddr,
    input  logic [VAL_W-1:0] ram_rdata
);

    localparam int XW = (CW > ENTRIES_W) ? CW : ENTRIES_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GET  = 3'd1;
    localparam logic [2:0] S_UP   = 3'd2;
    localparam logic [2:0] S_DN   = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    ils_in_t          op_reg, op_next;
    logic [CW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    pend_addr_reg, pend_addr_next;
    logic             pend_reg, pend_next;
    logic             reading_reg, reading_next;
    logic             found_reg, found_next;
    logic             ok_reg, ok_next;
    logic [VAL_W-1:0] rdv_reg, rdv_next;

    logic [XW-1:0]    in_pos_x, count_x;
    logic [CW-1:0]    in_pos_c, op_pos_c, in_pos_inc;
    logic [CW-1:0]    count_dec, count_inc;
    logic [CW-1:0]    pend_up, pend_dn;
    logic             in_pos_ok, full;

    assign in_pos_x   = XW'(cmd_word.position);
    assign count_x    = XW'(count_reg);
    assign in_pos_c   = CW'(cmd_word.position);
    assign op_pos_c   = CW'(op_reg.position);
    assign in_pos_inc = in_pos_c + ONE_C;
    assign count_dec  = count_reg - ONE_C;
    assign count_inc  = count_reg + ONE_C;
    assign pend_up    = pend_addr_reg + ONE_C;
    assign pend_dn    = pend_addr_reg - ONE_C;
    assign in_pos_ok  = in_pos_x < count_x;
    assign full       = count_reg == CAP_C;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        rd_ptr_next    = rd_ptr_reg;
        pend_addr_next = pend_addr_reg;
        pend_next      = pend_reg;
        reading_next   = reading_reg;
        found_next     = found_reg;
        ok_next        = ok_reg;
        rdv_next       = rdv_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        cmd_ready      = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    op_next      = cmd_word;
                    ok_next      = 1'b0;
                    rdv_next     = '0;
                    pend_next    = 1'b0;
                    found_next   = 1'b0;
                    reading_next = 1'b0;
                    state_next   = S_RESP;
                    case (cmd_word.command)
                        CMD_APPEND, CMD_INSERT:
                        begin
                            if (!full)
                            begin
                                if (cmd_word.command == CMD_INSERT && in_pos_ok)
                                begin
                                    reading_next = 1'b1;
                                    rd_ptr_next  = count_dec;
                                    state_next   = S_UP;
                                end
                                else
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = count_reg[AW-1:0];
                                    ram_wdata  = cmd_word.value;
                                    count_next = count_inc;
                                    ok_next    = 1'b1;
                                end
                            end
                        end
                        CMD_SET:
                        begin
                            if (in_pos_ok)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = in_pos_c[AW-1:0];
                                ram_wdata = cmd_word.value;
                                ok_next   = 1'b1;
                            end
                        end
                        CMD_GET:
                        begin
                            if (in_pos_ok)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = in_pos_c[AW-1:0];
                                state_next = S_GET;
                            end
                        end
                        CMD_REMOVE_VAL:
                        begin
                            if (count_reg != '0)
                            begin
                                reading_next = 1'b1;
                                rd_ptr_next  = '0;
                                state_next   = S_SCAN;
                            end
                        end
                        CMD_REMOVE_AT:
                        begin
                            if (in_pos_ok)
                            begin
                                if (in_pos_x + XW'(1) < count_x)
                                begin
                                    reading_next = 1'b1;
                                    rd_ptr_next  = in_pos_inc;
                                    state_next   = S_DN;
                                end
                                else
                                begin
                                    count_next = count_dec;
                                    ok_next    = 1'b1;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            ok_next    = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end

            S_GET:
            begin
                rdv_next   = ram_rdata;
                ok_next    = 1'b1;
                state_next = S_RESP;
            end

            S_UP:
            begin
                pend_next = reading_reg;
                if (reading_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = rd_ptr_reg[AW-1:0];
                    pend_addr_next = rd_ptr_reg;
                    if (rd_ptr_reg == op_pos_c)
                    begin
                        reading_next = 1'b0;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg - ONE_C;
                    end
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_up[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (!reading_reg && !pend_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = op_pos_c[AW-1:0];
                    ram_wdata  = op_reg.value;
                    count_next = count_inc;
                    ok_next    = 1'b1;
                    state_next = S_RESP;
                end
            end

            S_DN, S_SCAN:
            begin
                pend_next = reading_reg;
                if (reading_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = rd_ptr_reg[AW-1:0];
                    pend_addr_next = rd_ptr_reg;
                    if (rd_ptr_reg == count_dec)
                    begin
                        reading_next = 1'b0;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + ONE_C;
                    end
                end
                if (pend_reg)
                begin
                    if (state_reg == S_DN || found_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = pend_dn[AW-1:0];
                        ram_wdata = ram_rdata;
                    end
                    else if (ram_rdata == op_reg.value)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (!reading_reg && !pend_reg)
                begin
                    if (state_reg == S_DN || found_reg)
                    begin
                        count_next = count_dec;
                        ok_next    = 1'b1;
                    end
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            reading_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            reading_reg <= reading_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        rd_ptr_reg    <= rd_ptr_next;
        pend_addr_reg <= pend_addr_next;
        ok_reg        <= ok_next;
        rdv_reg       <= rdv_next;
    end

    logic [XW-1:0] entries_x;
    assign entries_x = XW'(count_reg);

    assign res_word.ok            = ok_reg;
    assign res_word.read_value    = rdv_reg;
    assign res_word.entries_after = entries_x[ENTRIES_W-1:0];

`ifndef NO_ASSERTIONS
    a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("read and write hit the same entry");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> !res_valid && !pend_reg)
        else $error("new word taken while work is in flight");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_word.command == CMD_CLEAR |=> count_reg == '0)
        else $error("clear left entries");
`endif

endmodule
